/* sv/c3zp_pkg.sv */
// Shared types and constants for the 3x3 zero-padded image filter.
`timescale 1ns / 1ps
`default_nettype none

package c3zp_pkg;

    typedef logic [23:0] t_pixel;

    // Live configuration, as held by the register file
    typedef struct packed {
        logic [10:0]        image_width;
        logic [10:0]        image_height;
        logic [2:0][47:0]   kernel;        // [0] top, [1] middle, [2] bottom
        logic               clamp_enable;
        logic signed [19:0] clamp_low;
        logic signed [19:0] clamp_high;
    } t_cfg;

    // One filter job: the 3x3 neighborhood plus its padding masks
    typedef struct packed {
        logic [2:0][2:0][23:0] win;        // [row][col], col 0 is left
        logic [2:0]            rv;         // row inside the image
        logic [2:0]            cv;         // column inside the image
        logic                  last;
    } t_win_item;

    typedef struct packed {
        logic signed [19:0] red;
        logic signed [19:0] green;
        logic signed [19:0] blue;
        logic               last;
    } t_result;

    typedef enum logic [2:0] {
        REG_WIDTH    = 3'd0,
        REG_HEIGHT   = 3'd1,
        REG_KTOP     = 3'd2,
        REG_KMID     = 3'd3,
        REG_KBOT     = 3'd4,
        REG_CLAMP_EN = 3'd5,
        REG_CLAMP_LO = 3'd6,
        REG_CLAMP_HI = 3'd7
    } t_reg_idx;

    localparam int                   ROW_W      = 13;
    localparam logic [ROW_W-1:0]     ROW_SAT    = 13'd4095;
    localparam logic [10:0]          MAX_HEIGHT = 11'd1024;
    localparam logic signed [19:0]   OUT_MAX    = 20'sh7FFFF;
    localparam logic signed [19:0]   OUT_MIN    = -20'sh80000;
    localparam int                   WIN_QDEPTH = 4;
    localparam int                   RES_QDEPTH = 8;

endpackage

`default_nettype wire

/* sv/c3zp_fifo.sv */
// Small register-based FIFO used for the window queue and the result queue.
`timescale 1ns / 1ps
`default_nettype none

module c3zp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [WIDTH-1:0]           i_data,
    input  wire logic                       i_pop,
    output logic [WIDTH-1:0]                o_data,
    output logic                            o_empty,
    output logic [$clog2(DEPTH+1)-1:0]      o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH+1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [NW-1:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

    // credit logic upstream must keep these from ever firing
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < NW'(DEPTH)))
        else $error("fifo overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("fifo underflow");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("fifo count did not follow a push");

endmodule

`default_nettype wire

/* sv/c3zp_front.sv */
// Front end: raster counters, line memory and the sliding 3x3 window.
`timescale 1ns / 1ps
`default_nettype none

module c3zp_front import c3zp_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire t_cfg                            i_cfg,
    input  wire logic                            i_push,
    input  wire logic                            i_req_type,
    input  wire t_pixel                          i_pixel,
    output logic                                 o_full,
    input  wire logic [$clog2(WIN_QDEPTH+1)-1:0] i_q_count,
    output logic                                 o_q_push,
    output t_win_item                            o_q_item
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int IW = $clog2(MAX_WIDTH);

    logic [CW-1:0]    r_in_col, r_out_col;
    logic [ROW_W-1:0] r_in_row, r_out_row;

    logic             r_s1_valid, r_s1_emit, r_s1_last;
    logic [IW-1:0]    r_s1_idx;
    t_pixel           r_s1_px;
    logic [2:0]       r_s1_rv, r_s1_cv;
    logic [47:0]      r_rdat;
    logic [2:0][2:0][23:0] r_win;

    logic [47:0]      r_line [MAX_WIDTH];

    logic [CW-1:0]    wc, col0, col1, oc0, oc1;
    logic [10:0]      hc;
    logic [ROW_W-1:0] hr, row0, row1, or0, or1;
    logic             accept, done, act, emit, last;
    logic [2:0]       rv, cv;
    t_pixel           px;
    logic [IW-1:0]    idx;
    logic [47:0]      wdata;
    logic [2:0][2:0][23:0] win_next;

    always_comb begin
        if (i_cfg.image_width == '0) begin
            wc = CW'(1);
        end else if (32'(i_cfg.image_width) > MAX_WIDTH) begin
            wc = CW'(MAX_WIDTH);
        end else begin
            wc = CW'(i_cfg.image_width);
        end
        if (i_cfg.image_height == '0) begin
            hc = 11'd1;
        end else if (i_cfg.image_height > MAX_HEIGHT) begin
            hc = MAX_HEIGHT;
        end else begin
            hc = i_cfg.image_height;
        end
        hr = ROW_W'(hc);

        accept = i_push && !o_full;
        done   = (r_in_row >= hr);
        act    = accept && !(i_req_type && !done);
        px     = (i_req_type || done) ? '0 : i_pixel;

        // column wraps late only when the width shrank mid frame
        if (r_in_col >= wc) begin
            col0 = '0;
            row0 = r_in_row + 1'b1;
        end else begin
            col0 = r_in_col;
            row0 = r_in_row;
        end
        idx  = col0[IW-1:0];
        emit = (row0 >= ROW_W'(2)) || ((row0 == ROW_W'(1)) && (col0 != '0));
        col1 = col0 + 1'b1;
        row1 = row0;
        if (col1 >= wc) begin
            col1 = '0;
            row1 = (row0 < ROW_SAT) ? row0 + 1'b1 : row0;
        end

        if (r_out_col >= wc) begin
            oc0 = '0;
            or0 = r_out_row + 1'b1;
        end else begin
            oc0 = r_out_col;
            or0 = r_out_row;
        end
        rv   = {(or0 + 1'b1) < hr, 1'b1, or0 != '0};
        cv   = {({1'b0, oc0} + 1'b1) < {1'b0, wc}, 1'b1, oc0 != '0};
        last = ((or0 + 1'b1) >= hr) && (({1'b0, oc0} + 1'b1) >= {1'b0, wc});
        oc1  = oc0 + 1'b1;
        or1  = or0;
        if (oc1 >= wc) begin
            oc1 = '0;
            or1 = or0 + 1'b1;
        end
    end

    // room for the item in stage 1 and the one accepted now
    assign o_full = (32'(i_q_count) + 32'(r_s1_valid)) >= WIN_QDEPTH;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_s1_valid <= 1'b0;
            r_win      <= '0;
        end else begin
            r_s1_valid <= act;
            if (act) begin
                if (emit && last) begin
                    r_in_col  <= '0;
                    r_in_row  <= '0;
                    r_out_col <= '0;
                    r_out_row <= '0;
                end else begin
                    r_in_col <= col1;
                    r_in_row <= row1;
                    if (emit) begin
                        r_out_col <= oc1;
                        r_out_row <= or1;
                    end
                end
            end
            if (r_s1_valid) begin
                r_win <= win_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx  <= idx;
        r_s1_px   <= px;
        r_s1_emit <= emit;
        r_s1_last <= last;
        r_s1_rv   <= rv;
        r_s1_cv   <= cv;
    end

    // line memory: upper row in 47:24, lower row in 23:0
    assign wdata = {r_rdat[23:0], r_s1_px};

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_line[r_s1_idx] <= wdata;
        end
        if (r_s1_valid && (r_s1_idx == idx)) begin
            r_rdat <= wdata;
        end else begin
            r_rdat <= r_line[idx];
        end
    end

    always_comb begin
        for (int kr = 0; kr < 3; kr++) begin
            win_next[kr][0] = r_win[kr][1];
            win_next[kr][1] = r_win[kr][2];
        end
        win_next[0][2] = r_rdat[47:24];
        win_next[1][2] = r_rdat[23:0];
        win_next[2][2] = r_s1_px;
    end

    assign o_q_push      = r_s1_valid && r_s1_emit;
    assign o_q_item.win  = win_next;
    assign o_q_item.rv   = r_s1_rv;
    assign o_q_item.cv   = r_s1_cv;
    assign o_q_item.last = r_s1_last;

endmodule

`default_nettype wire

/* sv/c3zp_back.sv */
// Back end: multiply, sum, scale, saturate and clamp for each color channel.
`timescale 1ns / 1ps
`default_nettype none

module c3zp_back import c3zp_pkg::*; #(
    parameter int COEF_FRACTION_BITS = 8,
    parameter int CHANNELS           = 3
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire t_cfg                            i_cfg,
    input  wire t_win_item                       i_q_item,
    input  wire logic                            i_q_empty,
    output logic                                 o_q_pop,
    input  wire logic [$clog2(RES_QDEPTH+1)-1:0] i_r_count,
    output logic                                 o_r_push,
    output t_result                              o_r_item
);

    localparam int PW = 25;
    localparam int RW = 27;
    localparam int SW = 29;

    logic                        r_va, r_vb, r_vc, r_vd;
    logic                        r_la, r_lb, r_lc;
    logic signed [PW-1:0]        r_prod [3][3][3];
    logic signed [RW-1:0]        r_rsum [3][3];
    logic signed [19:0]          r_sat  [3];
    t_result                     r_res;

    logic signed [PW-1:0]        prod   [3][3][3];
    logic signed [RW-1:0]        rsum   [3][3];
    logic signed [19:0]          sat    [3];
    logic signed [19:0]          clp    [3];
    logic signed [SW-1:0]        total, shifted;
    logic signed [15:0]          coef;
    logic [7:0]                  sample;
    int                          inflight;

    assign inflight = 32'(r_va) + 32'(r_vb) + 32'(r_vc) + 32'(r_vd);
    assign o_q_pop  = !i_q_empty && ((32'(i_r_count) + inflight) < RES_QDEPTH);

    always_comb begin
        coef   = '0;
        sample = '0;
        for (int ch = 0; ch < 3; ch++) begin
            for (int kr = 0; kr < 3; kr++) begin
                for (int kc = 0; kc < 3; kc++) begin
                    coef   = $signed(i_cfg.kernel[kr][16*kc +: 16]);
                    sample = i_q_item.win[kr][kc][8*ch +: 8];
                    if (i_q_item.rv[kr] && i_q_item.cv[kc]) begin
                        prod[ch][kr][kc] = PW'(coef) * PW'($signed({1'b0, sample}));
                    end else begin
                        prod[ch][kr][kc] = '0;
                    end
                end
                rsum[ch][kr] = RW'(r_prod[ch][kr][0]) + RW'(r_prod[ch][kr][1])
                             + RW'(r_prod[ch][kr][2]);
            end
        end
    end

    always_comb begin
        total   = '0;
        shifted = '0;
        for (int ch = 0; ch < 3; ch++) begin
            total   = SW'(r_rsum[ch][0]) + SW'(r_rsum[ch][1]) + SW'(r_rsum[ch][2]);
            shifted = total >>> COEF_FRACTION_BITS;
            if (ch >= CHANNELS) begin
                sat[ch] = '0;
            end else if (shifted > SW'(OUT_MAX)) begin
                sat[ch] = OUT_MAX;
            end else if (shifted < SW'(OUT_MIN)) begin
                sat[ch] = OUT_MIN;
            end else begin
                sat[ch] = shifted[19:0];
            end
            clp[ch] = r_sat[ch];
            if (i_cfg.clamp_enable && (ch < CHANNELS)) begin
                if (clp[ch] > i_cfg.clamp_high) begin
                    clp[ch] = i_cfg.clamp_high;
                end
                if (clp[ch] < i_cfg.clamp_low) begin
                    clp[ch] = i_cfg.clamp_low;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            r_va <= o_q_pop;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= prod;
        r_la   <= i_q_item.last;
        r_rsum <= rsum;
        r_lb   <= r_la;
        r_sat  <= sat;
        r_lc   <= r_lb;
        r_res  <= '{red: clp[0], green: clp[1], blue: clp[2], last: r_lc};
    end

    assign o_r_push = r_vd;
    assign o_r_item = r_res;

endmodule

`default_nettype wire

/* sv/image_conv3x3_zero_pad.sv */
// Top level of the streaming 3x3 zero-padded RGB filter with its register file.
// Usage:
//  - Pixels enter in raster order through a queue-style port: a transfer happens
//    when push is high and full is low. i_req_type 1 is a flush tick; after the
//    last pixel of a frame, width+1 flush ticks drain the remaining results.
//  - Results leave through a queue-style port: the oldest result sits on the
//    o_* ports while empty is low and is taken by pop. o_frame_last marks the
//    final pixel of the frame.
//  - Throughput: one pixel per clock sustained while the receiver keeps up.
//    The window queue (4 entries) and the result queue (8 entries) decouple
//    the two sides; full rises only when those queues run out of room.
//  - Path: the result for a pixel becomes available after the transfer of
//    the input item one row plus one pixel later, through line memory and
//    window, 4 multiply/sum/clamp stages and the result queue.
//  - Configuration goes through the APB port (64-bit data, register i at
//    byte 8*i); the user changes it only while the block is idle (not enforced).
//  - Reset (synchronous, active low) clears counters, window and queues; it
//    does not clear the line memory, whose stale contents are always masked
//    by the zero padding. A stalled receiver only backs up the result queue,
//    then the window queue, then raises full; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none

module image_conv3x3_zero_pad import c3zp_pkg::*; #(
    parameter int MAX_WIDTH          = 1024,
    parameter int COEF_FRACTION_BITS = 8,
    parameter int CHANNELS           = 3
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [5:0]         paddr,
    input  wire logic [63:0]        pwdata,
    output logic [63:0]             prdata,
    output logic                    pready,
    // pixel input
    input  wire logic               push,
    output logic                    full,
    input  wire logic               i_req_type,
    input  wire logic [7:0]         i_red_in,
    input  wire logic [7:0]         i_green_in,
    input  wire logic [7:0]         i_blue_in,
    // results
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [19:0]      o_red_out,
    output logic signed [19:0]      o_green_out,
    output logic signed [19:0]      o_blue_out,
    output logic                    o_frame_last
);

    t_cfg        r_cfg;
    t_reg_idx    reg_idx;
    logic        cfg_wr;

    logic        q_push, q_pop, q_empty;
    t_win_item   q_in, q_out;
    logic [$clog2(WIN_QDEPTH+1)-1:0] q_count;

    logic        r_push_res;
    t_result     res_in, res_out;
    logic [$clog2(RES_QDEPTH+1)-1:0] res_count;

    // register file
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[5:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= 11'd640;
            r_cfg.image_height <= 11'd480;
            r_cfg.kernel[0]    <= 48'd0;
            r_cfg.kernel[1]    <= 48'h000001000000;
            r_cfg.kernel[2]    <= 48'd0;
            r_cfg.clamp_enable <= 1'b1;
            r_cfg.clamp_low    <= 20'sd0;
            r_cfg.clamp_high   <= 20'sd255;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_WIDTH:    r_cfg.image_width  <= pwdata[10:0];
                REG_HEIGHT:   r_cfg.image_height <= pwdata[10:0];
                REG_KTOP:     r_cfg.kernel[0]    <= pwdata[47:0];
                REG_KMID:     r_cfg.kernel[1]    <= pwdata[47:0];
                REG_KBOT:     r_cfg.kernel[2]    <= pwdata[47:0];
                REG_CLAMP_EN: r_cfg.clamp_enable <= pwdata[0];
                REG_CLAMP_LO: r_cfg.clamp_low    <= $signed(pwdata[19:0]);
                REG_CLAMP_HI: r_cfg.clamp_high   <= $signed(pwdata[19:0]);
                default:      r_cfg              <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_WIDTH:    prdata = 64'(r_cfg.image_width);
            REG_HEIGHT:   prdata = 64'(r_cfg.image_height);
            REG_KTOP:     prdata = 64'(r_cfg.kernel[0]);
            REG_KMID:     prdata = 64'(r_cfg.kernel[1]);
            REG_KBOT:     prdata = 64'(r_cfg.kernel[2]);
            REG_CLAMP_EN: prdata = 64'(r_cfg.clamp_enable);
            REG_CLAMP_LO: prdata = 64'(unsigned'(r_cfg.clamp_low));
            REG_CLAMP_HI: prdata = 64'(unsigned'(r_cfg.clamp_high));
            default:      prdata = '0;
        endcase
    end

    // front: counters, line memory, window
    c3zp_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_push     (push),
        .i_req_type (i_req_type),
        .i_pixel    ({i_blue_in, i_green_in, i_red_in}),
        .o_full     (full),
        .i_q_count  (q_count),
        .o_q_push   (q_push),
        .o_q_item   (q_in)
    );

    // window jobs waiting for the arithmetic
    c3zp_fifo #(
        .WIDTH ($bits(t_win_item)),
        .DEPTH (WIN_QDEPTH)
    ) u_win_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    // back: multiply-accumulate and clamp
    c3zp_back #(
        .COEF_FRACTION_BITS (COEF_FRACTION_BITS),
        .CHANNELS           (CHANNELS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_item  (q_out),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_r_count (res_count),
        .o_r_push  (r_push_res),
        .o_r_item  (res_in)
    );

    // result queue feeding the output port
    c3zp_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RES_QDEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_push_res),
        .i_data  (res_in),
        .i_pop   (pop && !empty),
        .o_data  (res_out),
        .o_empty (empty),
        .o_count (res_count)
    );

    assign o_red_out    = res_out.red;
    assign o_green_out  = res_out.green;
    assign o_blue_out   = res_out.blue;
    assign o_frame_last = res_out.last;

endmodule

`default_nettype wire

/* sim/tb_image_conv3x3_zero_pad.sv */
// Self-checking testbench for the streaming 3x3 zero-padded RGB filter.
`timescale 1ns / 1ps

module tb_image_conv3x3_zero_pad;
    import c3zp_pkg::*;

    localparam int LINE_MAX   = 1024;
    localparam int FRAC_BITS  = 8;
    localparam int STALL_LIMIT = 5000;   // cycles with no transfer at all
    localparam int DRAIN_WAIT  = 20;     // pipeline depth plus margin

    typedef struct {
        logic       flush;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    logic        push = 1'b0;
    logic        full;
    logic        i_req_type = 1'b0;
    logic [7:0]  i_red_in = '0, i_green_in = '0, i_blue_in = '0;

    logic        empty;
    logic        pop = 1'b0;
    logic signed [19:0] o_red_out, o_green_out, o_blue_out;
    logic        o_frame_last;

    image_conv3x3_zero_pad i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .push         (push),
        .full         (full),
        .i_req_type   (i_req_type),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .empty        (empty),
        .pop          (pop),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_frame_last (o_frame_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Filter model: own copy of registers, line stores, window, counters
    // ---------------------------------------------------------------
    t_cfg        shadow_cfg;
    logic [23:0] upper_line [LINE_MAX];
    logic [23:0] lower_line [LINE_MAX];
    logic [23:0] window [3][3];          // [row][col], col 0 is left
    int unsigned in_row, in_col, out_row, out_col;

    t_in_item    pixel_q[$];             // items waiting for the driver
    t_result     filtered_q[$];          // results not yet seen at the output

    int  n_fail = 0;
    int  n_items = 0;
    int  n_results = 0;
    int  n_frames = 0;
    int  n_full_cycles = 0;
    bit  no_idle = 1'b0;                 // stretch without random gaps
    bit  hold_req = 1'b0;                // ask the receiver for a long hold-off

    function automatic logic signed [19:0] shape_result(longint acc);
        longint v;
        v = acc >>> FRAC_BITS;           // floor toward minus infinity
        if (v > longint'(OUT_MAX)) v = longint'(OUT_MAX);
        if (v < longint'(OUT_MIN)) v = longint'(OUT_MIN);
        if (shadow_cfg.clamp_enable) begin
            if (v > longint'(shadow_cfg.clamp_high)) v = longint'(shadow_cfg.clamp_high);
            if (v < longint'(shadow_cfg.clamp_low)) v = longint'(shadow_cfg.clamp_low);
        end
        return v[19:0];
    endfunction

    function automatic int unsigned eff_width();
        int unsigned w;
        w = 32'(shadow_cfg.image_width);
        if (w < 1) w = 1;
        if (w > LINE_MAX) w = LINE_MAX;
        return w;
    endfunction

    function automatic int unsigned eff_height();
        int unsigned h;
        h = 32'(shadow_cfg.image_height);
        if (h < 1) h = 1;
        if (h > 32'(MAX_HEIGHT)) h = 32'(MAX_HEIGHT);
        return h;
    endfunction

    // Advance the model by one accepted input item.
    task automatic filter_step(input t_in_item it);
        int unsigned w, h, idx;
        logic [23:0] px, top, mid;
        bit          done, emit, last;
        bit          rv[3], cv[3];
        longint      acc;
        logic signed [19:0] chan[3];
        t_result     res;
        w = eff_width();
        h = eff_height();
        px = '0;
        done = in_row >= h;
        if (it.flush && !done) return;   // early flush tick: ignored
        if (!it.flush && !done) px = {it.blue, it.green, it.red};
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        idx = (in_col < LINE_MAX) ? in_col : LINE_MAX - 1;
        top = upper_line[idx];
        mid = lower_line[idx];
        upper_line[idx] = mid;
        lower_line[idx] = px;
        for (int r = 0; r < 3; r++) begin
            window[r][0] = window[r][1];
            window[r][1] = window[r][2];
        end
        window[0][2] = top;
        window[1][2] = mid;
        window[2][2] = px;
        emit = in_row >= 2 || (in_row == 1 && in_col >= 1);
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            if (in_row < 4095) in_row++;
        end
        if (!emit) return;
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
        end
        rv[0] = out_row > 0;  rv[1] = 1'b1;  rv[2] = out_row + 1 < h;
        cv[0] = out_col > 0;  cv[1] = 1'b1;  cv[2] = out_col + 1 < w;
        for (int ch = 0; ch < 3; ch++) begin
            acc = 0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    if (rv[r] && cv[c])
                        acc += longint'($signed(shadow_cfg.kernel[r][16*c +: 16])) *
                               longint'(window[r][c][8*ch +: 8]);
            chan[ch] = shape_result(acc);
        end
        last = out_row + 1 >= h && out_col + 1 >= w;
        res.red = chan[0];
        res.green = chan[1];
        res.blue = chan[2];
        res.last = last;
        filtered_q.push_back(res);
        if (last) begin
            in_row = 0; in_col = 0; out_row = 0; out_col = 0;
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Pixel driver: one item at a time from pixel_q, random gaps
    // ---------------------------------------------------------------
    bit in_acc = 1'b0;
    bit out_acc = 1'b0;
    bit in_busy = 1'b0;
    int tx_gap = 0;

    always @(negedge i_clk) begin
        t_in_item it;
        if (in_acc) in_busy = 1'b0;
        if (!in_busy && i_rst_n) begin
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (pixel_q.size() > 0) begin
                it = pixel_q.pop_front();
                i_req_type <= it.flush;
                i_red_in   <= it.red;
                i_green_in <= it.green;
                i_blue_in  <= it.blue;
                in_busy = 1'b1;
                tx_gap = no_idle ? 0 : $urandom_range(0, 4);
            end
        end
        push <= in_busy;
    end

    // ---------------------------------------------------------------
    // Result receiver: random pop gaps plus one long hold-off
    // ---------------------------------------------------------------
    int rx_gap = 0;
    int hold_cnt = 0;

    always @(negedge i_clk) begin
        if (out_acc) rx_gap = no_idle ? 0 : $urandom_range(0, 4);
        if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = 400;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            pop <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            pop <= 1'b0;
        end else begin
            pop <= i_rst_n;
        end
    end

    // ---------------------------------------------------------------
    // Transfer monitor, checker and watchdog
    // ---------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        t_in_item it;
        t_result  want;
        in_acc  = i_rst_n && push && !full;
        out_acc = i_rst_n && pop && !empty;
        if (i_rst_n && push && full) n_full_cycles++;
        if (out_acc) begin
            n_results++;
            if (filtered_q.size() == 0) begin
                $error("result with nothing pending: r=%0d g=%0d b=%0d last=%0b",
                       o_red_out, o_green_out, o_blue_out, o_frame_last);
                n_fail++;
            end else begin
                want = filtered_q.pop_front();
                if (o_red_out !== want.red) begin
                    $error("red_out: expected %0d, got %0d", want.red, o_red_out);
                    n_fail++;
                end
                if (o_green_out !== want.green) begin
                    $error("green_out: expected %0d, got %0d", want.green, o_green_out);
                    n_fail++;
                end
                if (o_blue_out !== want.blue) begin
                    $error("blue_out: expected %0d, got %0d", want.blue, o_blue_out);
                    n_fail++;
                end
                if (o_frame_last !== want.last) begin
                    $error("frame_last: expected %0b, got %0b", want.last, o_frame_last);
                    n_fail++;
                end
                if (want.last) n_frames++;
            end
        end
        if (in_acc) begin
            it.flush = i_req_type;
            it.red   = i_red_in;
            it.green = i_green_in;
            it.blue  = i_blue_in;
            filter_step(it);
            n_items++;
        end
        if (!i_rst_n || in_acc || out_acc || psel) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    task automatic reg_write(input t_reg_idx idx, input logic [63:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_WIDTH:    shadow_cfg.image_width  = val[10:0];
            REG_HEIGHT:   shadow_cfg.image_height = val[10:0];
            REG_KTOP:     shadow_cfg.kernel[0]    = val[47:0];
            REG_KMID:     shadow_cfg.kernel[1]    = val[47:0];
            REG_KBOT:     shadow_cfg.kernel[2]    = val[47:0];
            REG_CLAMP_EN: shadow_cfg.clamp_enable = val[0];
            REG_CLAMP_LO: shadow_cfg.clamp_low    = val[19:0];
            REG_CLAMP_HI: shadow_cfg.clamp_high   = val[19:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [7:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_in_item make_item(input bit flush);
        t_in_item it;
        it.flush = flush;
        it.red   = pick_sample();
        it.green = pick_sample();
        it.blue  = pick_sample();
        return it;
    endfunction

    // One full frame at the current size: pixels, optional stray flush
    // ticks mid frame, then width+1 drain items (some of them pixels).
    task automatic queue_frame(input int noise_pct);
        int unsigned w, h;
        w = eff_width();
        h = eff_height();
        for (int unsigned i = 0; i < w * h; i++) begin
            if ($urandom_range(0, 99) < noise_pct) pixel_q.push_back(make_item(1'b1));
            pixel_q.push_back(make_item(1'b0));
        end
        for (int unsigned i = 0; i <= w; i++)
            pixel_q.push_back(make_item($urandom_range(0, 2) != 0));
    endtask

    task automatic wait_idle();
        wait (pixel_q.size() == 0 && !in_busy && filtered_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function automatic logic [47:0] rand_kernel_row();
        logic [47:0] k;
        case ($urandom_range(0, 3))
            0: k = 48'({$urandom(), $urandom()});                  // full range
            1: k = {16'($signed($urandom_range(0, 1024)) - 16'sd512),
                    16'($signed($urandom_range(0, 1024)) - 16'sd512),
                    16'($signed($urandom_range(0, 1024)) - 16'sd512)};
            2: k = {16'h8000, 16'h7FFF, 16'h8000};                 // extreme coefs
            default: k = {16'h0040, 16'h0080, 16'h0040};           // smoothing
        endcase
        return k;
    endfunction

    task automatic random_config();
        int lo, hi;
        reg_write(REG_WIDTH,  64'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                              : $urandom_range(1, 12)));
        reg_write(REG_HEIGHT, 64'($urandom_range(0, 8)));
        if (eff_width() * eff_height() > 64)
            reg_write(REG_WIDTH, 64'($urandom_range(1, 8)));
        reg_write(REG_KTOP, 64'(rand_kernel_row()));
        reg_write(REG_KMID, 64'(rand_kernel_row()));
        reg_write(REG_KBOT, 64'(rand_kernel_row()));
        reg_write(REG_CLAMP_EN, 64'($urandom_range(0, 1)));
        lo = $urandom_range(0, 3) == 0 ? int'($urandom_range(0, 1048575)) - 524288
                                       : int'($urandom_range(0, 400)) - 200;
        hi = $urandom_range(0, 3) == 0 ? int'($urandom_range(0, 1048575)) - 524288
                                       : int'($urandom_range(0, 600));
        reg_write(REG_CLAMP_LO, 64'(lo));
        reg_write(REG_CLAMP_HI, 64'(hi));
    endtask

    initial begin
        int phase;
        shadow_cfg.image_width  = 11'd640;
        shadow_cfg.image_height = 11'd480;
        shadow_cfg.kernel[0]    = 48'd0;
        shadow_cfg.kernel[1]    = 48'h000001000000;
        shadow_cfg.kernel[2]    = 48'd0;
        shadow_cfg.clamp_enable = 1'b1;
        shadow_cfg.clamp_low    = 20'sd0;
        shadow_cfg.clamp_high   = 20'sd255;
        for (int i = 0; i < LINE_MAX; i++) begin
            upper_line[i] = '0;
            lower_line[i] = '0;
        end
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                window[r][c] = '0;
        in_row = 0; in_col = 0; out_row = 0; out_col = 0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: 4x3 frame, kernel 1.0 above centre, -0.5/1.0/0.5 mid row,
        // clamp off, extreme samples, stray flush mid frame, pixel while draining.
        reg_write(REG_WIDTH, 64'd4);
        reg_write(REG_HEIGHT, 64'd3);
        reg_write(REG_KTOP, 64'h0000_0000_0100_0000);
        reg_write(REG_KMID, 64'h0000_0080_0100_FF80);
        reg_write(REG_KBOT, 64'h0000_0000_0000_0000);
        reg_write(REG_CLAMP_EN, 64'd0);
        for (int i = 0; i < 12; i++) begin
            pixel_q.push_back('{1'b0, (i % 2) ? 8'hFF : 8'h00,
                                (i % 3) ? 8'h00 : 8'hFF, 8'(i * 21)});
            if (i == 5) pixel_q.push_back('{1'b1, 8'h55, 8'hAA, 8'h55});
        end
        pixel_q.push_back('{1'b0, 8'hAA, 8'h55, 8'hAA});     // counts as a flush
        repeat (4) pixel_q.push_back('{1'b1, 8'h00, 8'h00, 8'h00});
        wait_idle();

        // Width 0 and height 0 both act as 1; inverted clamp bounds.
        reg_write(REG_WIDTH, 64'd0);
        reg_write(REG_HEIGHT, 64'd0);
        reg_write(REG_CLAMP_EN, 64'd1);
        reg_write(REG_CLAMP_LO, 64'd100);
        reg_write(REG_CLAMP_HI, 64'(-20));
        queue_frame(0);
        wait_idle();

        // Full-range clamp bounds on a small frame.
        reg_write(REG_CLAMP_LO, 64'hFFFF_FFFF_FFF8_0000);
        reg_write(REG_CLAMP_HI, 64'h7FFFF);
        reg_write(REG_WIDTH, 64'd5);
        reg_write(REG_HEIGHT, 64'd3);
        queue_frame(0);
        wait_idle();

        // Random phases: new settings, a few frames, back to idle.
        phase = 0;
        while (n_items < 700) begin
            random_config();
            no_idle = (phase % 5 == 2);
            if (phase == 1) begin
                reg_write(REG_WIDTH, 64'd10);
                reg_write(REG_HEIGHT, 64'd6);
                hold_req = 1'b1;          // receiver stalls while input keeps coming
            end
            repeat ($urandom_range(1, 3)) queue_frame($urandom_range(0, 1) ? 5 : 0);
            wait_idle();
            no_idle = 1'b0;
            phase++;
        end

        $display("%0d input items, %0d results, %0d frames over %0d setting phases",
                 n_items, n_results, n_frames, phase + 3);
        $display("input stalled by full for %0d cycles", n_full_cycles);
        if (n_fail == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
